>>> design/tgd_pkg.sv
// ----------------------------------------------------------------------------
// tgd_pkg
// Shared types and constants of the trilinear grid displacement block.
// ----------------------------------------------------------------------------
package tgd_pkg;

  localparam int GRID_SIDE     = 64;
  localparam int PARTICLE_SIDE = 1024;
  localparam int CELL_W        = $clog2(GRID_SIDE);
  localparam int ADDR_W        = 18;
  localparam int COORD_W       = $clog2(PARTICLE_SIDE);
  localparam int HALF_SHIFT    = $clog2(2 * GRID_SIDE);
  localparam int WGT_W         = 17;
  localparam int DATA_W        = 32;

  localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [2:0] {
    CFG_AXIS    = 3'd0,
    CFG_BOX     = 3'd1,
    CFG_SPACING = 3'd2,
    CFG_STEP    = 3'd3,
    CFG_GROWTH1 = 3'd4,
    CFG_GROWTH2 = 3'd5,
    CFG_RATE1   = 3'd6,
    CFG_RATE2   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_READ,
    ST_DRAIN,
    ST_PLANE0,
    ST_PLANE1,
    ST_FINAL,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_ROW,
    PH_PLANE0,
    PH_PLANE1,
    PH_FINAL
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   odd;
  } ictl_t;

endpackage

>>> design/tgd_ram.sv
// ----------------------------------------------------------------------------
// tgd_ram
// Generic synchronous RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tgd_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 18
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> design/tgd_interp.sv
// ----------------------------------------------------------------------------
// tgd_interp
// Trilinear blend of eight corner words streamed from one grid memory.
// ----------------------------------------------------------------------------
module tgd_interp import tgd_pkg::*; (
  input  logic                     clk_i,
  input  ictl_t                    ctl_i,
  input  logic signed [DATA_W-1:0] rdata_i,
  input  logic        [WGT_W-1:0]  wx_i,
  input  logic        [WGT_W-1:0]  wy_i,
  input  logic        [WGT_W-1:0]  wz_i,
  output logic signed [DATA_W-1:0] disp_o
);

  logic signed [DATA_W-1:0] prev_q;
  logic signed [DATA_W-1:0] row_q [4];
  logic signed [DATA_W-1:0] plane_q [2];
  logic signed [DATA_W-1:0] disp_q;

  logic signed [DATA_W-1:0] op_a, op_b, blend;
  logic        [WGT_W-1:0]  op_w, op_wn;
  logic signed [49:0]       prod_a, prod_b;
  logic signed [50:0]       sum;

  always_comb begin
    case (ctl_i.phase)
      PH_ROW: begin
        op_a = prev_q;
        op_b = rdata_i;
        op_w = wx_i;
      end
      PH_PLANE0: begin
        op_a = row_q[3];
        op_b = row_q[2];
        op_w = wy_i;
      end
      PH_PLANE1: begin
        op_a = row_q[1];
        op_b = row_q[0];
        op_w = wy_i;
      end
      PH_FINAL: begin
        op_a = plane_q[0];
        op_b = plane_q[1];
        op_w = wz_i;
      end
      default: begin
        op_a = prev_q;
        op_b = rdata_i;
        op_w = wx_i;
      end
    endcase
  end

  // a*w + b*(1-w), rounded to Q16
  always_comb begin
    op_wn  = ONE_Q16 - op_w;
    prod_a = op_a * $signed({1'b0, op_w});
    prod_b = op_b * $signed({1'b0, op_wn});
    sum    = 51'(prod_a) + 51'(prod_b) + 51'(32768);
    blend  = sum[47:16];
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.phase)
      PH_ROW: begin
        if (ctl_i.odd) begin
          row_q[3] <= row_q[2];
          row_q[2] <= row_q[1];
          row_q[1] <= row_q[0];
          row_q[0] <= blend;
        end else begin
          prev_q <= rdata_i;
        end
      end
      PH_PLANE0: plane_q[0] <= blend;
      PH_PLANE1: plane_q[1] <= blend;
      PH_FINAL:  disp_q     <= blend;
      default: ;
    endcase
  end

  assign disp_o = disp_q;

endmodule

>>> design/trilinear_grid_displacement_top.sv
// ----------------------------------------------------------------------------
// trilinear_grid_displacement_top
// Particle displacement by trilinear interpolation of two periodic grids.
// ----------------------------------------------------------------------------
// A load request writes one cell of both grids while busy stays low. A
// query keeps busy high through its steps: the split of the coordinates,
// eight corner reads through the single read port of each grid memory (both
// grids in parallel), a drain of the read latency, three blend steps, the
// four products through the shared 32x32 multiplier and a step to wrap and
// saturate. The result is shown on position_o/velocity_o with result_valid_o
// high for exactly one cycle, in the cycle a new request can be taken; the
// receiver cannot stall it, so it must take every strobe. Configuration
// writes are always ready and must only be made while busy is low.
module trilinear_grid_displacement_top import tgd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     req_type_i,
  input  logic        [17:0]       cell_index_i,
  input  logic signed [31:0]       first_disp_i,
  input  logic signed [31:0]       second_disp_i,
  input  logic        [9:0]        lattice_i_i,
  input  logic        [9:0]        lattice_j_i,
  input  logic        [9:0]        lattice_k_i,
  output logic                     result_valid_o,
  output logic signed [31:0]       position_o,
  output logic signed [31:0]       velocity_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic        [2:0]        cfg_index_i,
  input  logic        [31:0]       cfg_data_i
);

  state_e state_q, state_d;

  logic        [1:0]  axis_q;
  logic        [30:0] box_q, spacing_q, step_q;
  logic signed [31:0] growth1_q, growth2_q, rate1_q, rate2_q;

  logic [COORD_W-1:0] ci_q, cj_q, ck_q;
  logic [CELL_W-1:0]  cx_q, px_q, cy_q, py_q, cz_q, pz_q;
  logic [CELL_W-1:0]  cx_d, px_d, cy_d, py_d, cz_d, pz_d;
  logic [WGT_W-1:0]   wx_q, wy_q, wz_q, wx_d, wy_d, wz_d;
  logic [40:0]        gx, gy, gz, base;
  logic [COORD_W-1:0] sel_coord;

  logic [2:0] rd_cnt_q;
  logic [2:0] mul_cnt_q;
  logic       rd_vld_q, rd_odd_q;

  logic signed [51:0] pos_acc_q;
  logic signed [49:0] vel_acc_q;
  logic signed [47:0] prod_q;
  logic signed [63:0] mul_full;
  logic signed [31:0] mul_a, mul_b;

  logic signed [DATA_W-1:0] rdata1, rdata2, disp1, disp2;
  logic [ADDR_W-1:0]        raddr;
  logic [CELL_W-1:0]        ra, rb, rc;

  logic accept, load_we, rd_en;
  ictl_t ictl;

  logic signed [52:0] pos_w;
  logic signed [31:0] pos_sat, vel_sat;
  logic signed [31:0] position_q, velocity_q;
  logic               result_valid_q;

  assign accept      = start && !busy;
  assign load_we     = accept && !req_type_i;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q    <= AXIS_X;
      box_q     <= 31'd65536;
      spacing_q <= 31'd65536;
      step_q    <= 31'd65536;
      growth1_q <= 32'sd65536;
      growth2_q <= '0;
      rate1_q   <= '0;
      rate2_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_AXIS:    axis_q    <= cfg_data_i[1:0];
        CFG_BOX:     box_q     <= cfg_data_i[30:0];
        CFG_SPACING: spacing_q <= cfg_data_i[30:0];
        CFG_STEP:    step_q    <= cfg_data_i[30:0];
        CFG_GROWTH1: growth1_q <= cfg_data_i;
        CFG_GROWTH2: growth2_q <= cfg_data_i;
        CFG_RATE1:   rate1_q   <= cfg_data_i;
        CFG_RATE2:   rate2_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept && req_type_i) state_d = ST_SPLIT;
      ST_SPLIT:  state_d = ST_READ;
      ST_READ:   if (rd_cnt_q == 3'd7) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_PLANE0;
      ST_PLANE0: state_d = ST_PLANE1;
      ST_PLANE1: state_d = ST_FINAL;
      ST_FINAL:  state_d = ST_MUL;
      ST_MUL:    if (mul_cnt_q == 3'd4) state_d = ST_OUT;
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy       = 1'b1;
    rd_en      = 1'b0;
    ictl.odd   = rd_odd_q;
    ictl.phase = PH_NONE;
    case (state_q)
      ST_IDLE:   busy = 1'b0;
      ST_READ:   rd_en = 1'b1;
      ST_PLANE0: ictl.phase = PH_PLANE0;
      ST_PLANE1: ictl.phase = PH_PLANE1;
      ST_FINAL:  ictl.phase = PH_FINAL;
      default: ;
    endcase
    if (rd_vld_q) begin
      ictl.phase = PH_ROW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      rd_cnt_q       <= '0;
      mul_cnt_q      <= '0;
      rd_vld_q       <= 1'b0;
      rd_odd_q       <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      rd_vld_q       <= rd_en;
      rd_odd_q       <= rd_cnt_q[0];
      result_valid_q <= (state_q == ST_OUT);
      rd_cnt_q       <= (state_q == ST_READ) ? rd_cnt_q + 3'd1 : 3'd0;
      mul_cnt_q      <= (state_q == ST_MUL) ? mul_cnt_q + 3'd1 : 3'd0;
    end
  end

  // Coordinate split: grid coordinate = lattice * step, floor cell and fraction
  always_comb begin
    gx   = 41'(ci_q) * 41'(step_q);
    gy   = 41'(cj_q) * 41'(step_q);
    gz   = 41'(ck_q) * 41'(step_q);
    cx_d = gx[16 +: CELL_W];
    cy_d = gy[16 +: CELL_W];
    cz_d = gz[16 +: CELL_W];
    px_d = cx_d - CELL_W'(1);
    py_d = cy_d - CELL_W'(1);
    pz_d = cz_d - CELL_W'(1);
    wx_d = ONE_Q16 - {1'b0, gx[15:0]};
    wy_d = ONE_Q16 - {1'b0, gy[15:0]};
    wz_d = ONE_Q16 - {1'b0, gz[15:0]};
    case (axis_e'(axis_q))
      AXIS_Y:  sel_coord = cj_q;
      AXIS_Z:  sel_coord = ck_q;
      default: sel_coord = ci_q;
    endcase
    base = 41'(sel_coord) * 41'(spacing_q);
  end

  // Corner n: bit 2 picks the x cell (first index), bit 1 y, bit 0 z
  always_comb begin
    ra    = rd_cnt_q[2] ? px_q : cx_q;
    rb    = rd_cnt_q[1] ? py_q : cy_q;
    rc    = rd_cnt_q[0] ? pz_q : cz_q;
    raddr = ADDR_W'({ra, rb, rc});
  end

  // Shared multiplier over g1*d1, g2*d2, r1*d1, r2*d2
  always_comb begin
    case (mul_cnt_q)
      3'd0: begin mul_a = growth1_q; mul_b = disp1; end
      3'd1: begin mul_a = growth2_q; mul_b = disp2; end
      3'd2: begin mul_a = rate1_q;   mul_b = disp1; end
      3'd3: begin mul_a = rate2_q;   mul_b = disp2; end
      default: begin mul_a = rate2_q; mul_b = disp2; end
    endcase
    mul_full = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_type_i) begin
      ci_q <= lattice_i_i;
      cj_q <= lattice_j_i;
      ck_q <= lattice_k_i;
    end
    if (state_q == ST_SPLIT) begin
      cx_q      <= cx_d;
      px_q      <= px_d;
      cy_q      <= cy_d;
      py_q      <= py_d;
      cz_q      <= cz_d;
      pz_q      <= pz_d;
      wx_q      <= wx_d;
      wy_q      <= wy_d;
      wz_q      <= wz_d;
      pos_acc_q <= $signed({11'b0, base}) + $signed(52'(box_q >> HALF_SHIFT));
      vel_acc_q <= '0;
    end
    if (state_q == ST_MUL) begin
      prod_q <= 48'((mul_full + 64'sd32768) >>> 16);
      if (mul_cnt_q == 3'd1 || mul_cnt_q == 3'd2) begin
        pos_acc_q <= pos_acc_q + 52'(prod_q);
      end
      if (mul_cnt_q == 3'd3 || mul_cnt_q == 3'd4) begin
        vel_acc_q <= vel_acc_q + 50'(prod_q);
      end
    end
    if (state_q == ST_OUT) begin
      position_q <= pos_sat;
      velocity_q <= vel_sat;
    end
  end

  // Wrap once into the box, then saturate
  always_comb begin
    pos_w = 53'(pos_acc_q);
    if (pos_acc_q < 0) begin
      pos_w = 53'(pos_acc_q) + $signed({22'b0, box_q});
    end else if (53'(pos_acc_q) > $signed({22'b0, box_q})) begin
      pos_w = 53'(pos_acc_q) - $signed({22'b0, box_q});
    end
    if (pos_w > 53'sd2147483647) begin
      pos_sat = 32'sh7FFFFFFF;
    end else if (pos_w < -53'sd2147483648) begin
      pos_sat = 32'sh80000000;
    end else begin
      pos_sat = pos_w[31:0];
    end
    if (vel_acc_q > 50'sd2147483647) begin
      vel_sat = 32'sh7FFFFFFF;
    end else if (vel_acc_q < -50'sd2147483648) begin
      vel_sat = 32'sh80000000;
    end else begin
      vel_sat = vel_acc_q[31:0];
    end
  end

  tgd_ram #(.DATA_W(DATA_W), .ADDR_W(ADDR_W)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (cell_index_i),
    .wdata_i (first_disp_i),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata1)
  );

  tgd_ram #(.DATA_W(DATA_W), .ADDR_W(ADDR_W)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (cell_index_i),
    .wdata_i (second_disp_i),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata2)
  );

  tgd_interp u_first_interp (
    .clk_i   (clk_i),
    .ctl_i   (ictl),
    .rdata_i (rdata1),
    .wx_i    (wx_q),
    .wy_i    (wy_q),
    .wz_i    (wz_q),
    .disp_o  (disp1)
  );

  tgd_interp u_second_interp (
    .clk_i   (clk_i),
    .ctl_i   (ictl),
    .rdata_i (rdata2),
    .wx_i    (wx_q),
    .wy_i    (wy_q),
    .wz_i    (wz_q),
    .disp_o  (disp2)
  );

  assign result_valid_o = result_valid_q;
  assign position_o     = position_q;
  assign velocity_o     = velocity_q;

endmodule
